/* hdl/breakpoint_gain_curve_unit_assert.svh */
// Assertion macros for the gain curve unit checker.
// BGC_ASSERT expects clk_i and rst_ni, BGC_ASSERT_NORST only clk_i, to be visible where they are used.
`ifndef BREAKPOINT_GAIN_CURVE_UNIT_ASSERT_SVH
`define BREAKPOINT_GAIN_CURVE_UNIT_ASSERT_SVH

// Check on every rising edge outside reset.
`define BGC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge, reset included.
`define BGC_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/bgc_pkg.sv */
`timescale 1ns / 1ps

package bgc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = FRAC_BITS + 1;
  localparam int POINT_W   = 2 * COORD_W;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_EMPTY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_COUNT = CFG_IDX_W'(1);
  localparam int                   REG_POINT_BASE     = 2;

  // One classified item, handed from the front end to the interpolator
  typedef struct packed {
    logic               interp;  // 0: base is the final gain
    logic               neg;     // falling segment
    logic [COORD_W-1:0] base;    // left y, or the final gain
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] dt;
    logic [COORD_W-1:0] span;
  } job_t;

  function automatic logic [COORD_W-1:0] sat_one(logic [COORD_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

endpackage

/* hdl/bgc_front.sv */
`timescale 1ns / 1ps

module bgc_front #(
  parameter int MAX_INTERIOR = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bgc_pkg::COORD_W-1:0]  position_i,
  input  logic                         shape_empty_i,
  input  logic [bgc_pkg::COUNT_W-1:0]  interior_count_i,
  input  logic [bgc_pkg::POINT_W-1:0]  point_i [MAX_INTERIOR],
  output logic                         job_valid_o,
  output bgc_pkg::job_t                job_o,
  input  logic                         queue_full_i
);
  import bgc_pkg::*;

  localparam int SEGS  = MAX_INTERIOR + 1;
  localparam int SEG_W = $clog2(SEGS);

  logic [COORD_W-1:0] t;
  logic [COUNT_W-1:0] n_used;
  logic [COORD_W-1:0] px [MAX_INTERIOR];
  logic [COORD_W-1:0] py [MAX_INTERIOR];
  logic [COORD_W-1:0] lx [SEGS];
  logic [COORD_W-1:0] ly [SEGS];
  logic [COORD_W-1:0] rx [SEGS];
  logic [COORD_W-1:0] ry [SEGS];
  logic [SEGS-1:0]    hit;
  logic [SEG_W-1:0]   sel;
  logic               found;
  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [COORD_W-1:0] span, dt;
  logic               neg;
  job_t               job_d, job_q;
  logic               valid_d, valid_q;
  logic               load, push;

  assign t = sat_one(position_i);
  assign n_used = (interior_count_i > COUNT_W'(MAX_INTERIOR)) ?
                  COUNT_W'(MAX_INTERIOR) : interior_count_i;

  for (genvar k = 0; k < MAX_INTERIOR; k++) begin : g_pt
    assign px[k] = sat_one(point_i[k][COORD_W-1:0]);
    assign py[k] = sat_one(point_i[k][POINT_W-1:COORD_W]);
  end

  // Segment i runs from point i to point i+1; the right end closes the curve
  for (genvar i = 0; i < SEGS; i++) begin : g_seg
    if (i == 0) begin : g_first
      assign lx[i] = '0;
      assign ly[i] = '0;
    end else begin : g_inner
      assign lx[i] = px[i-1];
      assign ly[i] = py[i-1];
    end
    if (i < MAX_INTERIOR) begin : g_right
      assign rx[i] = (COUNT_W'(i) < n_used) ? px[i] : ONE;
      assign ry[i] = (COUNT_W'(i) < n_used) ? py[i] : ONE;
    end else begin : g_last
      assign rx[i] = ONE;
      assign ry[i] = ONE;
    end
    assign hit[i] = (COUNT_W'(i) <= n_used) && (t >= lx[i]) && (t <= rx[i]);
  end

  // First segment that holds the position wins
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = SEGS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel   = SEG_W'(i);
        found = 1'b1;
      end
    end
  end

  assign ax   = lx[sel];
  assign ay   = ly[sel];
  assign bx   = rx[sel];
  assign by   = ry[sel];
  assign span = bx - ax;
  assign dt   = t - ax;
  assign neg  = by < ay;

  always_comb begin
    job_d.interp = 1'b0;
    job_d.neg    = neg;
    job_d.base   = ay;
    job_d.dy     = neg ? (ay - by) : (by - ay);
    job_d.dt     = dt;
    job_d.span   = span;
    if (shape_empty_i) begin
      job_d.base = t;
    end else if (t == '0) begin
      job_d.base = '0;
    end else if (t == ONE || !found) begin
      job_d.base = ONE;
    end else if (span == '0) begin
      job_d.base = by;
    end else begin
      job_d.interp = 1'b1;
    end
  end

  assign push       = valid_q && !queue_full_i;
  assign in_stall_o = valid_q && queue_full_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (push ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = push;
  assign job_o       = job_q;

endmodule

/* hdl/bgc_queue.sv */
`timescale 1ns / 1ps

module bgc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bgc_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bgc_pkg::job_t head_o
);
  import bgc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_d, wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/bgc_back.sv */
`timescale 1ns / 1ps

module bgc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        queue_empty_i,
  input  bgc_pkg::job_t               job_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bgc_pkg::COORD_W-1:0] gain_o
);
  import bgc_pkg::*;

  localparam int DIV_STAGES = COORD_W;

  typedef struct packed {
    logic               interp;
    logic               neg;
    logic [COORD_W-1:0] base;
    logic [COORD_W-1:0] span;
    logic [PROD_W-1:0]  prod;
  } mul_t;

  typedef struct packed {
    logic               interp;
    logic               neg;
    logic [COORD_W-1:0] base;
    logic [COORD_W-1:0] span;
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] nq;   // numerator bits out, quotient bits in
  } div_t;

  logic                advance;
  logic                mul_valid_q;
  mul_t                mul_d, mul_q;
  logic [DIV_STAGES:0] div_valid_q;
  div_t                div_d [DIV_STAGES+1];
  div_t                div_q [DIV_STAGES+1];
  logic [PROD_W-1:0]   num;
  logic                out_valid_q;
  logic [COORD_W-1:0]  gain_d, gain_q;
  div_t                last;

  // The whole pipe moves together unless a finished result is held
  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !queue_empty_i;

  always_comb begin
    mul_d.interp = job_i.interp;
    mul_d.neg    = job_i.neg;
    mul_d.base   = job_i.base;
    mul_d.span   = job_i.span;
    mul_d.prod   = job_i.dy * job_i.dt;
  end

  assign num = mul_q.prod + PROD_W'(mul_q.span >> 1);

  always_comb begin
    div_d[0].interp = mul_q.interp;
    div_d[0].neg    = mul_q.neg;
    div_d[0].base   = mul_q.base;
    div_d[0].span   = mul_q.span;
    div_d[0].rem    = num[PROD_W-1:COORD_W];
    div_d[0].nq     = num[COORD_W-1:0];
  end

  // One restoring step per stage; for interpolated items the remainder stays below span
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [COORD_W:0] trial;
    logic [COORD_W:0] diff;
    logic             ge;
    assign trial = {div_q[k-1].rem, div_q[k-1].nq[COORD_W-1]};
    assign ge    = trial >= {1'b0, div_q[k-1].span};
    assign diff  = trial - {1'b0, div_q[k-1].span};
    always_comb begin
      div_d[k]      = div_q[k-1];
      div_d[k].rem  = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      div_d[k].nq   = {div_q[k-1].nq[COORD_W-2:0], ge};
    end
  end

  assign last = div_q[DIV_STAGES];

  always_comb begin
    gain_d = last.base;
    if (last.interp) begin
      gain_d = last.neg ? (last.base - last.nq) : (last.base + last.nq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      div_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      mul_valid_q <= pop_o;
      div_valid_q <= {div_valid_q[DIV_STAGES-1:0], mul_valid_q};
      out_valid_q <= div_valid_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mul_q  <= mul_d;
      div_q  <= div_d;
      gain_q <= gain_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gain_o      = gain_q;

endmodule

/* hdl/breakpoint_gain_curve_unit.sv */
// Throughput: one position per cycle when the output is not stalled; the divider
// is a 17-stage restoring pipe.
// in_stall_o rises only when the two-entry queue is full behind a held result.
// Reset (async, active low) empties the pipe and sets shape_empty = 1,
// interior_count = 0 and all points to 0, so gain follows position.
`timescale 1ns / 1ps

module breakpoint_gain_curve_unit #(
  parameter int MAX_INTERIOR = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // position channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bgc_pkg::COORD_W-1:0]   position_i,
  // gain channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bgc_pkg::COORD_W-1:0]   gain_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bgc_pkg::POINT_W-1:0]   cfg_data_i
);
  import bgc_pkg::*;

  logic               shape_empty_q;
  logic [COUNT_W-1:0] interior_count_q;
  logic [POINT_W-1:0] point_q [MAX_INTERIOR];
  logic               cfg_write;

  logic               job_push;
  job_t               job_front;
  logic               queue_full;
  logic               queue_pop;
  logic               queue_empty;
  job_t               job_head;

  // Register file: always ready, writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_empty_q    <= 1'b1;
      interior_count_q <= '0;
    end else if (cfg_write) begin
      if (cfg_index_i == REG_SHAPE_EMPTY) begin
        shape_empty_q <= cfg_data_i[0];
      end
      if (cfg_index_i == REG_INTERIOR_COUNT) begin
        interior_count_q <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < MAX_INTERIOR; k++) begin : g_point
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        point_q[k] <= '0;
      end else if (cfg_write && cfg_index_i == CFG_IDX_W'(REG_POINT_BASE + k)) begin
        point_q[k] <= cfg_data_i;
      end
    end
  end

  // Front end: saturate, find the segment, hold one classified item
  bgc_front #(
    .MAX_INTERIOR (MAX_INTERIOR)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .position_i       (position_i),
    .shape_empty_i    (shape_empty_q),
    .interior_count_i (interior_count_q),
    .point_i          (point_q),
    .job_valid_o      (job_push),
    .job_o            (job_front),
    .queue_full_i     (queue_full)
  );

  // Decouple the front end from the interpolator so each can stall alone
  bgc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_front),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .empty_o     (queue_empty),
    .head_o      (job_head)
  );

  // Back end: multiply, round, divide, apply offset, hold result
  bgc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .job_i         (job_head),
    .pop_o         (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .gain_o        (gain_o)
  );

endmodule

/* hdl/bgc_checker.sv */
`timescale 1ns / 1ps
`include "breakpoint_gain_curve_unit_assert.svh"

module bgc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [bgc_pkg::COORD_W-1:0] gain_o
);
  import bgc_pkg::*;

  // A held result keeps its value
  `BGC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(gain_o), "gain changed while stalled")

  // Gain never exceeds unity
  `BGC_ASSERT_NORST(a_gain_range, out_valid_o |-> gain_o <= ONE, "gain above unity")

  // Input backpressure only follows a stalled output
  `BGC_ASSERT(a_stall_cause, in_stall_o |-> $past(out_valid_o && out_stall_i), "input stalled without output stall")

endmodule

bind breakpoint_gain_curve_unit bgc_checker u_bgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .gain_o      (gain_o)
);

/* tb/breakpoint_gain_curve_unit_tb.sv */
`timescale 1ns / 1ps

module breakpoint_gain_curve_unit_tb;
  import bgc_pkg::*;

  localparam int NUM_POINTS       = 6;
  localparam int REG_LIMIT        = REG_POINT_BASE + NUM_POINTS;  // first ignored index
  localparam int LAST_INDEX       = (1 << CFG_IDX_W) - 1;
  localparam int NUM_PHASES       = 15;
  localparam int PHASE_ITEMS      = 125;
  localparam int DRAIN_CYCLES     = 40;    // leave a margin for the pipe to drain
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT      = 2000;

  typedef struct {
    logic [COORD_W-1:0] position;
    logic [COORD_W-1:0] gain;
  } gain_check_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [COORD_W-1:0]   position_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [COORD_W-1:0]   gain_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [POINT_W-1:0]   cfg_data_i  = '0;

  // Register image as the block should hold it; starts at its reset values
  logic                 cur_shape_empty = 1'b1;
  logic [COUNT_W-1:0]   cur_count       = '0;
  logic [POINT_W-1:0]   cur_point [NUM_POINTS] = '{default: '0};

  logic [COORD_W-1:0]   position_q [$];     // positions waiting to be offered
  gain_check_t          pending_gains [$];  // predicted gains, oldest first
  gain_check_t          oldest_gain;
  logic                 in_taken = 1'b0;
  int unsigned          mismatch_count = 0;
  int unsigned          quiet_cycles   = 0;
  int unsigned          send_idle_pct  = 16;
  int unsigned          recv_idle_pct  = 16;
  int unsigned          hold_requests  = 0;
  int unsigned          holds_granted  = 0;
  int unsigned          hold_left      = 0;

  breakpoint_gain_curve_unit #(
    .MAX_INTERIOR(NUM_POINTS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .gain_o      (gain_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Clamp a Q1.16 coordinate to unity
  function automatic logic [COORD_W-1:0] limit_unit(input logic [COORD_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // Gain for one position under the current register image
  function automatic logic [COORD_W-1:0] predict_gain(input logic [COORD_W-1:0] pos);
    logic [COORD_W-1:0] xs [NUM_POINTS+2];
    logic [COORD_W-1:0] ys [NUM_POINTS+2];
    logic [COORD_W-1:0] t;
    longint unsigned    span, dt, dy, q;
    int                 n;
    t = limit_unit(pos);
    if (cur_shape_empty) return t;
    // a count above the number of points acts as the full set
    n = (cur_count > NUM_POINTS) ? NUM_POINTS : int'(cur_count);
    xs[0] = '0;
    ys[0] = '0;
    for (int i = 0; i < n; i++) begin
      xs[i+1] = limit_unit(cur_point[i][COORD_W-1:0]);
      ys[i+1] = limit_unit(cur_point[i][POINT_W-1:COORD_W]);
    end
    xs[n+1] = ONE;
    ys[n+1] = ONE;
    if (t == 0) return '0;
    if (t == ONE) return ONE;
    // first segment whose x range holds the position wins
    for (int i = 0; i <= n; i++) begin
      if (t < xs[i] || t > xs[i+1]) continue;
      span = xs[i+1] - xs[i];
      if (span == 0) return ys[i+1];
      dt = t - xs[i];
      // round the offset to nearest, ties away from the left y
      if (ys[i+1] >= ys[i]) begin
        dy = ys[i+1] - ys[i];
        q  = (dy * dt + span / 2) / span;
        return ys[i] + COORD_W'(q);
      end
      dy = ys[i] - ys[i+1];
      q  = (dy * dt + span / 2) / span;
      return ys[i] - COORD_W'(q);
    end
    // no segment held the position: fall back to the right end
    return ONE;
  endfunction

  function automatic logic [POINT_W-1:0] pack_point(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
    return {y, x};
  endfunction

  function automatic logic [POINT_W-1:0] random_word();
    return POINT_W'({$urandom, $urandom});
  endfunction

  // Bias positions towards the ends, the breakpoints and the saturated range
  function automatic logic [COORD_W-1:0] random_position();
    int          sel;
    int          v;
    int unsigned k;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return ONE;
    if (sel < 22) return COORD_W'($urandom);
    if (sel < 35) begin
      k = $urandom_range(NUM_POINTS - 1);
      v = int'(cur_point[k][COORD_W-1:0]) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
      return COORD_W'(v);
    end
    return COORD_W'($urandom_range(ONE));
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Write one register over the config channel and mirror it in the image
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POINT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_SHAPE_EMPTY) cur_shape_empty = data[0];
    else if (idx == REG_INTERIOR_COUNT) cur_count = data[COUNT_W-1:0];
    else if (idx < REG_LIMIT) cur_point[idx - REG_POINT_BASE] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every position is in and every gain is out, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (position_q.size() != 0 || in_valid_i || pending_gains.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_random_curve(input int phase);
    logic [COORD_W-1:0] xs [$];
    logic [POINT_W-1:0] data;
    logic [COORD_W-1:0] y;
    int                 style;
    int unsigned        cnt;
    style = phase % 3;
    // junk in the upper bits must be dropped by the block
    data = random_word();
    data[0] = (phase % 5 == 4);
    write_reg(REG_SHAPE_EMPTY, data);
    if (phase == 0) cnt = 0;
    else if (phase == 1) cnt = 7;
    else if (phase == 2) cnt = NUM_POINTS;
    else cnt = $urandom_range(7);
    data = random_word();
    data[COUNT_W-1:0] = COUNT_W'(cnt);
    write_reg(REG_INTERIOR_COUNT, data);
    for (int k = 0; k < NUM_POINTS; k++) begin
      if (style == 2) begin
        case ($urandom_range(2))
          0: xs.push_back('0);
          1: xs.push_back(ONE);
          default: xs.push_back(COORD_W'($urandom_range(ONE)));
        endcase
      end else begin
        xs.push_back(COORD_W'($urandom_range(ONE)));
      end
    end
    xs.sort();
    for (int k = 0; k < NUM_POINTS; k++) begin
      if (phase == 1) data = '1;                  // both coordinates saturate
      else if (phase == 2) data = '0;             // every point on the origin
      else if (style == 1) data = random_word();  // unordered, any bits
      else begin
        y = (style == 2) ? ($urandom_range(1) ? ONE : '0) : COORD_W'($urandom_range(ONE));
        data = pack_point(xs[k], y);
      end
      write_reg(CFG_IDX_W'(REG_POINT_BASE + k), data);
    end
    // an index past the register list must leave everything untouched
    write_reg(CFG_IDX_W'($urandom_range(LAST_INDEX, REG_LIMIT)), random_word());
  endtask

  // Sender: offer the next position once the held one has transferred
  always @(negedge clk_i) begin
    if (rst_ni && (in_taken || !in_valid_i)) begin
      if (position_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        position_i <= position_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  always @(negedge clk_i) begin
    if (holds_granted != hold_requests) begin
      holds_granted = hold_requests;
      hold_left     = LONG_HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predict on each input transfer, check each output transfer in order
  always @(posedge clk_i) begin
    in_taken = in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_taken) pending_gains.push_back('{position_i, predict_gain(position_i)});
      if (out_valid_o && !out_stall_i) begin
        if (pending_gains.size() == 0) begin
          report_mismatch($sformatf("gain %0d with no position outstanding", gain_o));
        end else begin
          oldest_gain = pending_gains.pop_front();
          if (gain_o !== oldest_gain.gain)
            report_mismatch($sformatf("position %0d: gain %0d, predicted %0d",
                                      oldest_gain.position, gain_o, oldest_gain.gain));
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the curve is empty: gain follows the saturated position
    position_q = '{'0, COORD_W'(1), COORD_W'(32768), COORD_W'(65535), ONE,
                   COORD_W'(65537), COORD_W'(131071), COORD_W'(17'h0AAAA),
                   COORD_W'(17'h15555)};
    wait_idle();

    // Hand-built curve: rounding ties both ways, a duplicate x, a saturated
    // point, an unordered tail, and a count past the number of points
    write_reg(REG_SHAPE_EMPTY, 34'h2_AAAA_AAAA);
    write_reg(REG_INTERIOR_COUNT, 34'h3_5555_5557);
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 0), pack_point(COORD_W'(2), COORD_W'(1)));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 1), pack_point(COORD_W'(4), '0));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 2), pack_point(COORD_W'(30000), ONE));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 3), pack_point(COORD_W'(30000), COORD_W'(20000)));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 4), pack_point('1, '1));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 5), pack_point(COORD_W'(50000), COORD_W'(100)));
    write_reg(CFG_IDX_W'(LAST_INDEX), '1);
    write_reg(CFG_IDX_W'(REG_LIMIT), 34'h1);
    @(posedge clk_i);
    position_q = '{COORD_W'(1), COORD_W'(2), COORD_W'(3), COORD_W'(4), COORD_W'(5),
                   COORD_W'(29999), COORD_W'(30000), COORD_W'(30001), COORD_W'(40000),
                   COORD_W'(65535), COORD_W'(131071), '0};
    wait_idle();

    // Random curves, each phase drained before the registers change
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // one phase runs flat out on both sides
      send_idle_pct = (phase == 3) ? 0 : 16;
      recv_idle_pct = (phase == 3) ? 0 : 16;
      load_random_curve(phase);
      @(posedge clk_i);
      for (int i = 0; i < PHASE_ITEMS; i++) position_q.push_back(random_position());
      // back-pressure the output long enough to fill the pipe and stall the input
      if (phase == 6) hold_requests++;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
